// ===== sv/sun_vector_from_pyramid_sensors_unit_assert.svh =====
// Assertion helpers for the sun vector unit.
// Both macros check on the rising clock edge and are disabled while reset is low.
`ifndef SUN_VECTOR_FROM_PYRAMID_SENSORS_UNIT_ASSERT_SVH
`define SUN_VECTOR_FROM_PYRAMID_SENSORS_UNIT_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define SUNVEC_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("sun vector unit: same-cycle check failed");

// The consequent must hold in the cycle after the antecedent.
`define SUNVEC_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("sun vector unit: next-cycle check failed");

`endif

// ===== sv/sunvec_pkg.sv =====
package sunvec_pkg;

    localparam int FIELD_BITS        = 16;
    localparam int OUT_BITS          = 16;
    localparam int NUM_FACES         = 8;
    localparam int NUM_LANES         = 3;
    localparam int SAMPLE_BITS_DEF   = 16;
    localparam int FRACTION_BITS_DEF = 14;

    typedef struct packed {
        logic [FIELD_BITS-1:0] intensity_0;
        logic [FIELD_BITS-1:0] intensity_1;
        logic [FIELD_BITS-1:0] intensity_2;
        logic [FIELD_BITS-1:0] intensity_3;
        logic [FIELD_BITS-1:0] intensity_4;
        logic [FIELD_BITS-1:0] intensity_5;
        logic [FIELD_BITS-1:0] intensity_6;
        logic [FIELD_BITS-1:0] intensity_7;
    } t_sensor_in;

    typedef struct packed {
        logic signed [OUT_BITS-1:0] sun_x;
        logic signed [OUT_BITS-1:0] sun_y;
        logic signed [OUT_BITS-1:0] sun_z;
        logic                       dark;
    } t_sun_out;

endpackage

// ===== sv/sun_vector_from_pyramid_sensors_unit.sv =====
// Throughput: one transaction per cycle in every pipeline stage while the result is not stalled.
// The divider lanes retire one quotient bit per stage, so FRACTION_BITS + 1 of the stages
// are divider stages; the rest form differences, sums, the maximum and the final sign.
// A stalled result freezes the whole pipeline and stalls the input in the same cycle.
// Reset clears every valid bit; data registers are not reset.
module sun_vector_from_pyramid_sensors_unit #(
    parameter int SAMPLE_BITS   = sunvec_pkg::SAMPLE_BITS_DEF,
    parameter int FRACTION_BITS = sunvec_pkg::FRACTION_BITS_DEF
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_in_valid,
    input  sunvec_pkg::t_sensor_in i_in_data,
    output logic                   o_in_stall,
    output logic                   o_out_valid,
    input  logic                   i_out_stall,
    output sunvec_pkg::t_sun_out   o_out_data
);

    localparam int FB   = sunvec_pkg::FIELD_BITS;
    localparam int OB   = sunvec_pkg::OUT_BITS;
    localparam int NL   = sunvec_pkg::NUM_LANES;
    localparam int NF   = sunvec_pkg::NUM_FACES;
    localparam int EW   = (SAMPLE_BITS < FB) ? SAMPLE_BITS : FB;
    localparam int DW   = EW + 2;
    localparam int QW   = FRACTION_BITS + 1;
    localparam int NDIV = QW;
    localparam int CW   = (QW > OB + 1) ? QW : OB + 1;

    localparam logic [CW-1:0] MAG_NEG = CW'(2 ** (OB - 1));
    localparam logic [CW-1:0] MAG_POS = MAG_NEG - CW'(1);

    function automatic logic [DW:0] div_step(input logic [DW:0] trial,
                                             input logic [DW-1:0] den);
        logic [DW:0] diff;
        diff = trial - {1'b0, den};
        if (trial >= {1'b0, den}) begin
            return {1'b1, diff[DW-1:0]};
        end
        return {1'b0, trial[DW-1:0]};
    endfunction

    logic w_adv;
    assign o_in_stall = o_out_valid & i_out_stall;
    assign w_adv      = ~o_in_stall;

    logic [EW-1:0] w_sample [NF];
    assign w_sample[0] = i_in_data.intensity_0[EW-1:0];
    assign w_sample[1] = i_in_data.intensity_1[EW-1:0];
    assign w_sample[2] = i_in_data.intensity_2[EW-1:0];
    assign w_sample[3] = i_in_data.intensity_3[EW-1:0];
    assign w_sample[4] = i_in_data.intensity_4[EW-1:0];
    assign w_sample[5] = i_in_data.intensity_5[EW-1:0];
    assign w_sample[6] = i_in_data.intensity_6[EW-1:0];
    assign w_sample[7] = i_in_data.intensity_7[EW-1:0];

    // Stage 1: opposing-pair differences and pairwise maxima.
    logic                r1_valid;
    logic signed [EW:0]  r1_diff [4];
    logic signed [EW:0]  n1_diff [4];
    logic [EW-1:0]       r1_pmax [4];
    logic [EW-1:0]       n1_pmax [4];

    always_comb begin
        n1_diff[0] = $signed({1'b0, w_sample[0]}) - $signed({1'b0, w_sample[6]});
        n1_diff[1] = $signed({1'b0, w_sample[1]}) - $signed({1'b0, w_sample[5]});
        n1_diff[2] = $signed({1'b0, w_sample[2]}) - $signed({1'b0, w_sample[4]});
        n1_diff[3] = $signed({1'b0, w_sample[3]}) - $signed({1'b0, w_sample[7]});
        for (int k = 0; k < 4; k++) begin
            n1_pmax[k] = (w_sample[2*k] > w_sample[2*k+1]) ? w_sample[2*k] : w_sample[2*k+1];
        end
    end

    // Stage 2: matrix sums and the overall maximum.
    logic                  r2_valid;
    logic signed [EW+2:0]  r2_sx;
    logic signed [EW+1:0]  r2_sy;
    logic signed [EW+1:0]  r2_sz;
    logic [EW-1:0]         r2_peak;
    logic signed [EW+2:0]  n2_sx;
    logic signed [EW+1:0]  n2_sy;
    logic signed [EW+1:0]  n2_sz;
    logic [EW-1:0]         n2_peak;
    logic [EW-1:0]         w_max_lo;
    logic [EW-1:0]         w_max_hi;

    always_comb begin
        n2_sx = (EW+3)'(r1_diff[0]) + (EW+3)'(r1_diff[1])
              + (EW+3)'(r1_diff[2]) + (EW+3)'(r1_diff[3]);
        n2_sy = (EW+2)'(r1_diff[3]) - (EW+2)'(r1_diff[1]);
        n2_sz = (EW+2)'(r1_diff[2]) - (EW+2)'(r1_diff[0]);
        w_max_lo = (r1_pmax[0] > r1_pmax[1]) ? r1_pmax[0] : r1_pmax[1];
        w_max_hi = (r1_pmax[2] > r1_pmax[3]) ? r1_pmax[2] : r1_pmax[3];
        n2_peak  = (w_max_lo > w_max_hi) ? w_max_lo : w_max_hi;
    end

    // Stage 3: magnitudes, signs and per-lane divisors.
    logic                  r3_valid;
    logic                  r3_dark;
    logic [DW-1:0]         r3_mag [NL];
    logic [DW-1:0]         r3_den [NL];
    logic [NL-1:0]         r3_neg;
    logic [DW-1:0]         n3_mag [NL];
    logic [DW-1:0]         n3_den [NL];
    logic [NL-1:0]         n3_neg;
    logic signed [EW+2:0]  w_neg_sx;
    logic signed [EW+1:0]  w_neg_sy;
    logic signed [EW+1:0]  w_neg_sz;

    always_comb begin
        w_neg_sx  = -r2_sx;
        w_neg_sy  = -r2_sy;
        w_neg_sz  = -r2_sz;
        n3_neg[0] = r2_sx[EW+2];
        n3_neg[1] = r2_sy[EW+1];
        n3_neg[2] = r2_sz[EW+1];
        n3_mag[0] = n3_neg[0] ? DW'(w_neg_sx) : DW'(r2_sx);
        n3_mag[1] = n3_neg[1] ? DW'(w_neg_sy) : DW'(r2_sy);
        n3_mag[2] = n3_neg[2] ? DW'(w_neg_sz) : DW'(r2_sz);
        n3_den[0] = {r2_peak, 2'b00};
        n3_den[1] = {1'b0, r2_peak, 1'b0};
        n3_den[2] = {1'b0, r2_peak, 1'b0};
    end

    // Divider stages: one restoring step per stage on each lane.
    logic [NDIV-1:0]  r_dv_valid;
    logic [NDIV-1:0]  r_dv_dark;
    logic [NL-1:0]    r_dv_neg [NDIV];
    logic [DW-1:0]    r_dv_den [NDIV][NL];
    logic [DW-1:0]    r_dv_rem [NDIV][NL];
    logic [QW-1:0]    r_dv_quo [NDIV][NL];
    logic [DW-1:0]    n_dv_rem [NDIV][NL];
    logic [QW-1:0]    n_dv_quo [NDIV][NL];

    always_comb begin
        logic [DW:0] step;
        for (int l = 0; l < NL; l++) begin
            step = div_step({1'b0, r3_mag[l]}, r3_den[l]);
            n_dv_rem[0][l] = step[DW-1:0];
            n_dv_quo[0][l] = QW'(step[DW]);
        end
        for (int d = 1; d < NDIV; d++) begin
            for (int l = 0; l < NL; l++) begin
                step = div_step({r_dv_rem[d-1][l], 1'b0}, r_dv_den[d-1][l]);
                n_dv_rem[d][l] = step[DW-1:0];
                n_dv_quo[d][l] = {r_dv_quo[d-1][l][QW-2:0], step[DW]};
            end
        end
    end

    // Output stage: sign, saturation and the all-dark case.
    logic [OB-1:0]         w_comp [NL];
    sunvec_pkg::t_sun_out  n_out;
    logic                  r_out_valid;
    sunvec_pkg::t_sun_out  r_out_data;

    always_comb begin
        logic [CW-1:0] qe;
        for (int l = 0; l < NL; l++) begin
            qe = CW'(r_dv_quo[NDIV-1][l]);
            if (r_dv_dark[NDIV-1]) begin
                w_comp[l] = '0;
            end else if (r_dv_neg[NDIV-1][l]) begin
                w_comp[l] = (qe > MAG_NEG) ? OB'(MAG_NEG) : OB'(-qe);
            end else begin
                w_comp[l] = (qe > MAG_POS) ? OB'(MAG_POS) : OB'(qe);
            end
        end
        n_out.sun_x = $signed(w_comp[0]);
        n_out.sun_y = $signed(w_comp[1]);
        n_out.sun_z = $signed(w_comp[2]);
        n_out.dark  = r_dv_dark[NDIV-1];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_valid    <= 1'b0;
            r2_valid    <= 1'b0;
            r3_valid    <= 1'b0;
            r_dv_valid  <= '0;
            r_out_valid <= 1'b0;
        end else if (w_adv) begin
            r1_valid    <= i_in_valid;
            r2_valid    <= r1_valid;
            r3_valid    <= r2_valid;
            r_dv_valid  <= {r_dv_valid[NDIV-2:0], r3_valid};
            r_out_valid <= r_dv_valid[NDIV-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r1_diff   <= n1_diff;
            r1_pmax   <= n1_pmax;
            r2_sx     <= n2_sx;
            r2_sy     <= n2_sy;
            r2_sz     <= n2_sz;
            r2_peak   <= n2_peak;
            r3_mag    <= n3_mag;
            r3_den    <= n3_den;
            r3_neg    <= n3_neg;
            r3_dark   <= (r2_peak == '0);
            r_dv_dark <= {r_dv_dark[NDIV-2:0], r3_dark};
            r_dv_neg[0] <= r3_neg;
            r_dv_den[0] <= r3_den;
            for (int d = 1; d < NDIV; d++) begin
                r_dv_neg[d] <= r_dv_neg[d-1];
                r_dv_den[d] <= r_dv_den[d-1];
            end
            r_dv_rem   <= n_dv_rem;
            r_dv_quo   <= n_dv_quo;
            r_out_data <= n_out;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

endmodule

// ===== sv/sunvec_checker.sv =====
`include "sun_vector_from_pyramid_sensors_unit_assert.svh"

module sunvec_checker (
    input logic                   i_clk,
    input logic                   i_rst_n,
    input logic                   o_in_stall,
    input logic                   o_out_valid,
    input logic                   i_out_stall,
    input sunvec_pkg::t_sun_out   o_out_data
);

    logic w_vec_zero;
    assign w_vec_zero = (o_out_data.sun_x == '0) && (o_out_data.sun_y == '0)
                      && (o_out_data.sun_z == '0);

    `SUNVEC_ASSERT_NXT(a_valid_held, i_clk, i_rst_n, o_out_valid && i_out_stall, o_out_valid)
    `SUNVEC_ASSERT_NXT(a_data_held, i_clk, i_rst_n, o_out_valid && i_out_stall, $stable(o_out_data))
    `SUNVEC_ASSERT_IMP(a_stall_cause, i_clk, i_rst_n, o_in_stall, o_out_valid && i_out_stall)
    `SUNVEC_ASSERT_IMP(a_dark_zero, i_clk, i_rst_n, o_out_valid && o_out_data.dark, w_vec_zero)

endmodule

bind sun_vector_from_pyramid_sensors_unit sunvec_checker u_sunvec_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_in_stall  (o_in_stall),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_out_data  (o_out_data)
);

// ===== bench/sun_vector_from_pyramid_sensors_unit_tb.sv =====
module sun_vector_from_pyramid_sensors_unit_tb;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int LATENCY     = sunvec_pkg::FRACTION_BITS_DEF + 5;
    localparam int HOLD_CYCLES = 150;
    localparam int CYCLE_LIMIT = 300_000;
    localparam int FB          = sunvec_pkg::FIELD_BITS;
    localparam int NF          = sunvec_pkg::NUM_FACES;

    logic                   clk       = 1'b0;
    logic                   rst_n     = 1'b0;
    logic                   in_valid  = 1'b0;
    sunvec_pkg::t_sensor_in in_data   = '0;
    logic                   in_stall;
    logic                   out_valid;
    logic                   out_stall = 1'b0;
    sunvec_pkg::t_sun_out   out_data;

    sunvec_pkg::t_sun_out pending_vectors[$];
    int       mismatch_count  = 0;
    int       sets_sent       = 0;
    int       vectors_checked = 0;
    int       dark_seen       = 0;
    int       cycle_count     = 0;
    int       send_idle_pct   = 28;
    int       recv_idle_pct   = 65;
    bit       hold_kick       = 1'b0;
    bit       hold_seen       = 1'b0;
    int       hold_left       = 0;

    sun_vector_from_pyramid_sensors_unit dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .i_in_data   (in_data),
        .o_in_stall  (in_stall),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_data  (out_data)
    );

    always #5 clk = ~clk;

    function automatic logic signed [sunvec_pkg::OUT_BITS-1:0] scaled_quotient(longint num,
                                                                               int shift,
                                                                               longint den);
        longint mag;
        longint q;
        mag = (num < 0) ? -num : num;
        q = (mag << shift) / den;
        if (num < 0) begin
            return (q > 32768) ? 16'sh8000 : 16'(-q);
        end
        return (q > 32767) ? 16'sh7fff : 16'(q);
    endfunction

    function automatic sunvec_pkg::t_sun_out predict_sun_vector(sunvec_pkg::t_sensor_in s);
        logic [FB-1:0]        raw [NF];
        longint               face [NF];
        longint               peak;
        longint               sx;
        longint               sy;
        longint               sz;
        sunvec_pkg::t_sun_out r;
        raw[0] = s.intensity_0;
        raw[1] = s.intensity_1;
        raw[2] = s.intensity_2;
        raw[3] = s.intensity_3;
        raw[4] = s.intensity_4;
        raw[5] = s.intensity_5;
        raw[6] = s.intensity_6;
        raw[7] = s.intensity_7;
        peak = 0;
        for (int k = 0; k < NF; k++) begin
            face[k] = longint'(raw[k])
                    & ((longint'(1) << sunvec_pkg::SAMPLE_BITS_DEF) - 1);
            if (face[k] > peak) begin
                peak = face[k];
            end
        end
        r = '0;
        if (peak == 0) begin
            r.dark = 1'b1;
            return r;
        end
        sx = (face[0] - face[6]) + (face[1] - face[5]) + (face[2] - face[4])
           + (face[3] - face[7]);
        sy = (face[3] - face[7]) - (face[1] - face[5]);
        sz = (face[2] - face[4]) - (face[0] - face[6]);
        r.sun_x = scaled_quotient(sx, sunvec_pkg::FRACTION_BITS_DEF - 2, peak);
        r.sun_y = scaled_quotient(sy, sunvec_pkg::FRACTION_BITS_DEF - 1, peak);
        r.sun_z = scaled_quotient(sz, sunvec_pkg::FRACTION_BITS_DEF - 1, peak);
        return r;
    endfunction

    function automatic sunvec_pkg::t_sensor_in pack_faces(logic [FB-1:0] f [NF]);
        sunvec_pkg::t_sensor_in s;
        s.intensity_0 = f[0];
        s.intensity_1 = f[1];
        s.intensity_2 = f[2];
        s.intensity_3 = f[3];
        s.intensity_4 = f[4];
        s.intensity_5 = f[5];
        s.intensity_6 = f[6];
        s.intensity_7 = f[7];
        return s;
    endfunction

    function automatic sunvec_pkg::t_sensor_in random_sensor_set();
        logic [FB-1:0] f [NF];
        int            mode;
        int            base;
        mode = $urandom_range(19);
        base = $urandom_range(65535);
        for (int k = 0; k < NF; k++) begin
            if (mode < 10) begin
                f[k] = 16'($urandom_range(65535));
            end else if (mode < 13) begin
                f[k] = 16'($urandom_range(15));
            end else if (mode < 16) begin
                f[k] = $urandom_range(1) ? 16'($urandom_range(65535)) : '0;
            end else if (mode < 18) begin
                f[k] = 16'(base ^ $urandom_range(7));
            end else if (mode < 19) begin
                f[k] = (k == base % NF) ? 16'(65535 - $urandom_range(3))
                                        : 16'($urandom_range(255));
            end else begin
                f[k] = '0;
            end
        end
        return pack_faces(f);
    endfunction

    task automatic send_sensor_set(sunvec_pkg::t_sensor_in s);
        while ($urandom_range(99) < send_idle_pct) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= s;
        do @(posedge clk); while (in_stall);
        pending_vectors.push_back(predict_sun_vector(s));
        sets_sent++;
    endtask

    task automatic release_and_drain();
        in_valid <= 1'b0;
        do @(posedge clk); while (pending_vectors.size() != 0);
    endtask

    task automatic test_directed_corners();
        logic [FB-1:0] f [NF];
        f = '{default: 16'h0000};
        send_sensor_set(pack_faces(f));
        f = '{default: 16'hffff};
        send_sensor_set(pack_faces(f));
        for (int k = 0; k < NF; k++) begin
            f = '{default: 16'h0000};
            f[k] = 16'hffff;
            send_sensor_set(pack_faces(f));
        end
        f = '{default: 16'h0000};
        f[3] = 16'h0001;
        send_sensor_set(pack_faces(f));
        f = '{16'hffff, 16'hffff, 16'hffff, 16'hffff, 16'h0, 16'h0, 16'h0, 16'h0};
        send_sensor_set(pack_faces(f));
        f = '{16'h0, 16'h0, 16'h0, 16'h0, 16'hffff, 16'hffff, 16'hffff, 16'hffff};
        send_sensor_set(pack_faces(f));
        f = '{16'h0, 16'h0, 16'h0, 16'hffff, 16'h0, 16'hffff, 16'h0, 16'h0};
        send_sensor_set(pack_faces(f));
        f = '{16'h0, 16'hffff, 16'h0, 16'h0, 16'h0, 16'h0, 16'h0, 16'hffff};
        send_sensor_set(pack_faces(f));
        f = '{16'h0, 16'h0, 16'hffff, 16'h0, 16'h0, 16'h0, 16'hffff, 16'h0};
        send_sensor_set(pack_faces(f));
        f = '{16'hffff, 16'h0, 16'h0, 16'h0, 16'hffff, 16'h0, 16'h0, 16'h0};
        send_sensor_set(pack_faces(f));
        f = '{16'haaaa, 16'h5555, 16'haaaa, 16'h5555, 16'haaaa, 16'h5555, 16'haaaa, 16'h5555};
        send_sensor_set(pack_faces(f));
        f = '{16'h5555, 16'haaaa, 16'h5555, 16'haaaa, 16'h5555, 16'haaaa, 16'h5555, 16'haaaa};
        send_sensor_set(pack_faces(f));
        f = '{16'd1, 16'd2, 16'd0, 16'd0, 16'd0, 16'd0, 16'd3, 16'd0};
        send_sensor_set(pack_faces(f));
        f = '{16'd0, 16'd0, 16'd5, 16'd7, 16'd1, 16'd0, 16'd0, 16'd2};
        send_sensor_set(pack_faces(f));
        release_and_drain();
    endtask

    task automatic test_random_sets(int count, int send_pct, int recv_pct);
        send_idle_pct = send_pct;
        recv_idle_pct = recv_pct;
        for (int n = 0; n < count; n++) begin
            send_sensor_set(random_sensor_set());
        end
        release_and_drain();
    endtask

    task automatic test_output_hold_off();
        send_idle_pct = 0;
        recv_idle_pct = 0;
        hold_kick = ~hold_kick;
        for (int n = 0; n < 60; n++) begin
            send_sensor_set(random_sensor_set());
        end
        release_and_drain();
    endtask

    always @(posedge clk) begin
        if (hold_kick != hold_seen) begin
            hold_seen = hold_kick;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left > 0) begin
            hold_left--;
            out_stall <= 1'b1;
        end else begin
            out_stall <= ($urandom_range(99) < recv_idle_pct);
        end
    end

    function automatic void compare_field(string name, int expected_val, int actual_val);
        if (expected_val != actual_val) begin
            $error("%s mismatch: expected %0d, actual %0d", name, expected_val, actual_val);
            mismatch_count++;
        end
    endfunction

    always @(posedge clk) begin
        sunvec_pkg::t_sun_out want;
        if (rst_n && out_valid && !out_stall) begin
            if (pending_vectors.size() == 0) begin
                $error("unexpected result transaction: x %0d y %0d z %0d dark %0b",
                       out_data.sun_x, out_data.sun_y, out_data.sun_z, out_data.dark);
                mismatch_count++;
            end else begin
                want = pending_vectors.pop_front();
                compare_field("sun_x", want.sun_x, out_data.sun_x);
                compare_field("sun_y", want.sun_y, out_data.sun_y);
                compare_field("sun_z", want.sun_z, out_data.sun_z);
                compare_field("dark", want.dark, out_data.dark);
                vectors_checked++;
                if (want.dark) begin
                    dark_seen++;
                end
            end
        end
    end

    always @(posedge clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles with %0d results outstanding.",
                     cycle_count, pending_vectors.size());
            $display("Regression FAIL");
            $finish;
        end
    end

    initial begin
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed_corners();
        test_random_sets(300, 28, 65);
        test_random_sets(300, 65, 28);
        test_random_sets(300, 0, 0);
        test_output_hold_off();
        repeat (2 * LATENCY) @(posedge clk);
        $display("Sent %0d sensor sets, %0d of them dark, under three idle mixes",
                 sets_sent, dark_seen);
        $display("and a long hold-off; checked %0d sun vectors, %0d mismatches.",
                 vectors_checked, mismatch_count);
        if (mismatch_count == 0 && pending_vectors.size() == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
+incdir+sv
sv/sunvec_pkg.sv
sv/sun_vector_from_pyramid_sensors_unit.sv
sv/sunvec_checker.sv
bench/sun_vector_from_pyramid_sensors_unit_tb.sv
